// ----- hdl/sssg_pkg.sv -----
`default_nettype none
package sssg_pkg;

  localparam int ATAN_LEN = 24;
  localparam logic signed [33:0] GAIN_Q30 = 34'sh026DD3B6A;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic [5:0]         segments;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic               last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
    logic [5:0]         steps;
    logic [31:0]        az_step;
    logic [31:0]        pol_step;
  } job_t;

  // angle step table, one entry per count 0..32
  typedef logic [32:0][31:0] step_tab_t;

  // CORDIC arctangent table, phase units (2^32 per turn)
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // azimuth step floor(sqrt(floor((2^64-1)/n))): largest a with a*a*n <= 2^64-1
  function automatic step_tab_t build_az_tab();
    step_tab_t   t;
    logic [31:0] a, trial;
    logic [71:0] sq;
    t = '0;
    for (int n = 1; n <= 32; n++) begin
      a = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = a | (32'd1 << b);
        sq = {40'd0, trial} * {40'd0, trial} * 72'(n);
        if (sq <= {8'd0, 64'hFFFFFFFFFFFFFFFF}) a = trial;
      end
      t[6'(n)] = a;
    end
    return t;
  endfunction

  // polar step floor(2^31/n): largest p with p*n <= 2^31
  function automatic step_tab_t build_pol_tab();
    step_tab_t   t;
    logic [31:0] p, trial;
    logic [71:0] pr;
    t = '0;
    for (int n = 1; n <= 32; n++) begin
      p = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = p | (32'd1 << b);
        pr = {40'd0, trial} * 72'(n);
        if (pr <= 72'h80000000) p = trial;
      end
      t[6'(n)] = p;
    end
    return t;
  endfunction

  localparam step_tab_t AZ_STEP_TAB  = build_az_tab();
  localparam step_tab_t POL_STEP_TAB = build_pol_tab();

  function automatic logic [31:0] az_step_of(input logic [5:0] n);
    return AZ_STEP_TAB[n];
  endfunction

  function automatic logic [31:0] pol_step_of(input logic [5:0] n);
    return POL_STEP_TAB[n];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sssg_front.sv -----
`default_nettype none
// Accepts requests, clamps the count, looks up angle steps, queues jobs.
module sssg_front #(
  parameter int MAX_STEPS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sssg_pkg::in_item_t in_data,
  output logic                   job_valid,
  input  wire logic              job_take,
  output sssg_pkg::job_t         job_data
);
  import sssg_pkg::*;

  // two-entry queue
  job_t        q_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;
  logic        acc, push, pop;
  logic [5:0]  n_cl;
  job_t        job_new;

  always_comb begin
    n_cl = (in_data.segments > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : in_data.segments;
    job_new.center_x = in_data.center_x;
    job_new.center_y = in_data.center_y;
    job_new.center_z = in_data.center_z;
    job_new.radius   = in_data.radius;
    job_new.steps    = n_cl;
    job_new.az_step  = az_step_of(n_cl);
    job_new.pol_step = pol_step_of(n_cl);
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign acc       = in_valid && !in_stall;
  // zero count makes no job
  assign push      = acc && (n_cl != 6'd0);
  assign job_valid = (cnt_r != 2'd0);
  assign pop       = job_valid && job_take;
  assign job_data  = q_r[rp_r];
  assign cnt_nxt   = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job_new;
  end
endmodule
`default_nettype wire

// ----- hdl/sssg_back.sv -----
`default_nettype none
// Walks the spiral: shared CORDIC, shared multiplier, emits segments.
module sssg_back #(
  parameter int CORDIC_ROUNDS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             job_valid,
  output logic                  job_take,
  input  wire sssg_pkg::job_t   job_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sssg_pkg::out_item_t   out_data
);
  import sssg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_CSET = 4'd1, S_CRUN = 4'd2,
                         S_M1 = 4'd3, S_M2 = 4'd4, S_M3 = 4'd5, S_M4 = 4'd6,
                         S_M5 = 4'd7, S_M6 = 4'd8, S_FIN = 4'd9,
                         S_EMIT1 = 4'd10, S_EMIT2 = 4'd11;

  logic [3:0]         st_r, st_nxt;
  job_t               job_r;
  logic [5:0]         k_r;
  logic [31:0]        az_r, pol_r;
  logic               which_r;  // 0 azimuth, 1 polar
  logic [4:0]         rnd_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [1:0]         q_r;
  logic signed [33:0] c1_r, s1_r, c2_r, s2_r;
  logic signed [33:0] t1_r, t2_r;
  logic signed [63:0] px_r, py_r, pz_r;
  logic signed [31:0] prv_x_r, prv_y_r, prv_z_r, prv_m_r;
  logic signed [31:0] cur_x_r, cur_y_r, cur_z_r, cur_m_r;
  logic               first_r;
  logic               ov_r;
  out_item_t          od_r;

  // shared multiplier with Q30 rounding
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  logic signed [37:0] mr;
  assign mp = ma * mb;
  assign mr = 38'((mp + 68'sd536870912) >>> 30);

  function automatic logic signed [31:0] sat(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic [31:0]        ph, zd;
  logic [1:0]         qn;
  logic signed [33:0] dx, dy;
  logic signed [33:0] rad_s;
  logic signed [33:0] cs, sn;
  assign ph    = which_r ? pol_r : az_r;
  assign qn    = 2'((ph + 32'h20000000) >> 30);
  assign zd    = ph - {qn, 30'd0};
  assign dx    = cy_r >>> rnd_r;
  assign dy    = cx_r >>> rnd_r;
  assign rad_s = {3'b000, job_r.radius};

  // quadrant fix-up
  always_comb begin
    unique case (q_r)
      2'd0: begin cs = cx_r;  sn = cy_r;  end
      2'd1: begin cs = -cy_r; sn = cx_r;  end
      2'd2: begin cs = -cx_r; sn = -cy_r; end
      default: begin cs = cy_r; sn = -cx_r; end
    endcase
  end

  // operands follow the capture order: t1, t2, x, z, y
  always_comb begin
    ma = s2_r; mb = c1_r;
    unique case (st_r)
      S_M2: begin ma = s2_r; mb = c1_r; end
      S_M3: begin ma = s2_r; mb = s1_r; end
      S_M4: begin ma = t1_r; mb = rad_s; end
      S_M5: begin ma = t2_r; mb = rad_s; end
      S_M6: begin ma = c2_r; mb = rad_s; end
      default: ;
    endcase
  end

  assign job_take = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (job_valid) st_nxt = S_CSET;
      S_CSET:  st_nxt = S_CRUN;
      S_CRUN:  if (rnd_r == 5'(CORDIC_ROUNDS - 1)) st_nxt = which_r ? S_M1 : S_CSET;
      S_M1:    st_nxt = S_M2;
      S_M2:    st_nxt = S_M3;
      S_M3:    st_nxt = S_M4;
      S_M4:    st_nxt = S_M5;
      S_M5:    st_nxt = S_M6;
      S_M6:    st_nxt = S_FIN;
      S_FIN:   st_nxt = first_r ? S_CSET : S_EMIT1;
      S_EMIT1: if (!ov_r || !out_stall) st_nxt = S_EMIT2;
      S_EMIT2: if (!ov_r || !out_stall)
                 st_nxt = (k_r == job_r.steps) ? S_IDLE : S_CSET;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if ((st_r == S_EMIT1 || st_r == S_EMIT2) && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: begin
        job_r <= job_data; k_r <= '0; az_r <= '0; pol_r <= '0;
        which_r <= 1'b0; first_r <= 1'b1;
      end
      S_CSET: begin
        q_r <= qn; cz_r <= 34'(signed'(zd)); cx_r <= GAIN_Q30; cy_r <= '0;
        rnd_r <= '0;
      end
      S_CRUN: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - dx; cy_r <= cy_r + dy;
          cz_r <= cz_r - 34'(atan_turn(rnd_r));
        end else begin
          cx_r <= cx_r + dx; cy_r <= cy_r - dy;
          cz_r <= cz_r + 34'(atan_turn(rnd_r));
        end
        rnd_r <= rnd_r + 5'd1;
        if (rnd_r == 5'(CORDIC_ROUNDS - 1)) which_r <= !which_r;
      end
      S_M1: begin
        c2_r <= cs; s2_r <= sn;
        t1_r <= '0;
      end
      default: ;
    endcase
    // azimuth result captured when polar run starts
    if (st_r == S_CSET && which_r) begin c1_r <= cs; s1_r <= sn; end
    if (st_r == S_M2) t1_r <= 34'(mr);
    if (st_r == S_M3) t2_r <= 34'(mr);
    if (st_r == S_M4) px_r <= 64'(mr);
    if (st_r == S_M5) pz_r <= 64'(mr);
    if (st_r == S_M6) py_r <= 64'(mr);
    if (st_r == S_FIN) begin
      prv_x_r <= cur_x_r; prv_y_r <= cur_y_r; prv_z_r <= cur_z_r; prv_m_r <= cur_m_r;
      cur_x_r <= sat(40'(job_r.center_x) + 40'(px_r));
      cur_y_r <= sat(40'(job_r.center_y) + 40'(py_r));
      cur_z_r <= sat(40'(job_r.center_z) + 40'(pz_r));
      cur_m_r <= sat(40'(job_r.center_z) - 40'(pz_r));
      first_r <= 1'b0;
      // k counts finished steps; the start point is not one
      if (!first_r) k_r <= k_r + 6'd1;
      az_r <= az_r + job_r.az_step;
      pol_r <= pol_r + job_r.pol_step;
    end
    if (st_r == S_EMIT1 && (!ov_r || !out_stall)) begin
      od_r <= '{prv_x_r, prv_y_r, prv_z_r, cur_x_r, cur_y_r, cur_z_r, 1'b0};
    end
    if (st_r == S_EMIT2 && (!ov_r || !out_stall)) begin
      od_r <= '{prv_x_r, prv_y_r, prv_m_r, cur_x_r, cur_y_r, cur_m_r,
                k_r == job_r.steps};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sphere_spiral_segment_generator_top.sv -----
// Sphere spiral segment generator.
// Input channel (in_valid/in_stall/in_data) takes one request: centre,
// radius and step count n (clamped to MAX_STEPS). Output channel
// (out_valid/out_stall/out_data) gives 2n segments per request, spiral piece
// then its z-mirrored copy, with last set on the final one. n = 0 gives none.
// A front part classifies requests and looks up the angle steps; a
// two-entry job queue separates it from the back part, so up to two
// requests are taken while the back part works.
// Each spiral point takes two CORDIC runs, azimuth then polar, on one
// shared unit, then a multiply and sum on the shared multiplier. A request
// takes (n+1) points, the start point included, plus the output of the
// spiral piece and its mirrored copy for each step.
// Synchronous active-low reset empties the queue and drops any output.
// A stalled output holds its segment; the back part waits on it and the
// queue fills, then in_stall rises.
`default_nettype none
module sphere_spiral_segment_generator_top #(
  parameter int MAX_STEPS = 32,
  parameter int CORDIC_ROUNDS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sssg_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sssg_pkg::out_item_t      out_data
);
  import sssg_pkg::*;

  logic job_valid, job_take;
  job_t job_data;

  sssg_front #(.MAX_STEPS(MAX_STEPS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid, .job_take, .job_data
  );

  sssg_back #(.CORDIC_ROUNDS(CORDIC_ROUNDS)) u_back (
    .clk, .rst_n, .job_valid, .job_take, .job_data,
    .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

// ----- hdl/sssg_checker.sv -----
`default_nettype none
module sssg_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire sssg_pkg::out_item_t out_data
);
  // a stalled segment holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");

  // no output in the cycle after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // segments come in pairs: a last segment never follows a transfer of a last
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !(out_valid && out_data.last))
    else $error("two last segments in a row");

  // input stall clear after reset
  a_istall: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");
endmodule

bind sphere_spiral_segment_generator_top sssg_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);
`default_nettype wire

// ----- tb/sphere_spiral_segment_generator_top_tb.sv -----
`default_nettype none
module sphere_spiral_segment_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sssg_pkg::*;

  localparam int MAX_STEPS = 32;
  localparam int CORDIC_ROUNDS = 16;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int RANDOM_ITEMS = 200;
  localparam longint HALF_Q30 = 64'sd1 << 29;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pending_reqs[$];
  out_item_t seg_expected[$];
  int        total_reqs;
  int        reqs_sent = 0;
  int        segs_seen = 0;
  int        mismatches = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  longint    cycles = 0;

  sphere_spiral_segment_generator_top #(
    .MAX_STEPS(MAX_STEPS),
    .CORDIC_ROUNDS(CORDIC_ROUNDS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // arctangent of 2^-i in phase units
  function automatic longint atan_phase(input int i);
    logic [31:0] t[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return longint'({32'd0, t[i]});
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + HALF_Q30) >>> 30;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // cosine and sine of a phase, Q2.30
  task automatic cordic_sincos(input logic [31:0] phase, output longint c, output longint s);
    logic [1:0]  q;
    logic [31:0] zd;
    longint      x, y, z, dx, dy;
    q = 2'((phase + 32'h20000000) >> 30);
    zd = phase - ({30'd0, q} << 30);
    z = longint'(signed'(zd));
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_ROUNDS && i < ATAN_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_phase(i);
      end else begin
        x += dx; y -= dy; z += atan_phase(i);
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  // spiral point: x, y, z and mirrored z
  task automatic sphere_point(input logic [31:0] az, input logic [31:0] pol,
                              input in_item_t req, output longint p[4]);
    longint c1, s1, c2, s2, r, zt;
    r = longint'({33'd0, req.radius});
    cordic_sincos(az, c1, s1);
    cordic_sincos(pol, c2, s2);
    p[0] = clamp32(longint'(req.center_x) + round_q30(round_q30(s2 * c1) * r));
    p[1] = clamp32(longint'(req.center_y) + round_q30(c2 * r));
    zt = round_q30(round_q30(s2 * s1) * r);
    p[2] = clamp32(longint'(req.center_z) + zt);
    p[3] = clamp32(longint'(req.center_z) - zt);
  endtask

  // segments a request produces, appended in output order
  task automatic predict_spiral(input in_item_t req);
    int          n;
    logic [31:0] az_inc, pol_inc;
    longint      prev[4], cur[4];
    out_item_t   seg;
    n = (req.segments > MAX_STEPS) ? MAX_STEPS : int'(req.segments);
    if (n == 0) return;
    az_inc = 32'(int_sqrt(64'hFFFFFFFFFFFFFFFF / 64'(n)));
    pol_inc = 32'(64'h80000000 / 64'(n));
    sphere_point(32'd0, 32'd0, req, prev);
    for (int k = 1; k <= n; k++) begin
      sphere_point(az_inc * 32'(k), pol_inc * 32'(k), req, cur);
      seg.start_x = 32'(prev[0]); seg.start_y = 32'(prev[1]); seg.start_z = 32'(prev[2]);
      seg.end_x = 32'(cur[0]);    seg.end_y = 32'(cur[1]);    seg.end_z = 32'(cur[2]);
      seg.last = 1'b0;
      seg_expected = {seg_expected, seg};
      seg.start_z = 32'(prev[3]);
      seg.end_z = 32'(cur[3]);
      seg.last = (k == n);
      seg_expected = {seg_expected, seg};
      prev = cur;
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic in_item_t make_req(input logic [31:0] cx, input logic [31:0] cy,
                                        input logic [31:0] cz, input logic [30:0] r,
                                        input logic [5:0] n);
    in_item_t t;
    t.center_x = cx; t.center_y = cy; t.center_z = cz; t.radius = r; t.segments = n;
    return t;
  endfunction

  // appends one request to the pending queue
  function automatic void queue_req(input logic [31:0] cx, input logic [31:0] cy,
                                    input logic [31:0] cz, input logic [30:0] r,
                                    input logic [5:0] n);
    pending_reqs = {pending_reqs, make_req(cx, cy, cz, r, n)};
  endfunction

  // driver: requests go out from the pending queue, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_spiral(in_data);
        reqs_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 30 && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_data <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each segment transfer, stalls in random bursts
  always @(posedge clk) begin
    out_item_t exp_seg;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      segs_seen++;
      if (seg_expected.size() == 0) begin
        $display("%0t: unexpected segment, expected none actual %h", $realtime, out_data);
        mismatches++;
      end else begin
        exp_seg = seg_expected.pop_front();
        check_field("start_x", exp_seg.start_x, out_data.start_x);
        check_field("start_y", exp_seg.start_y, out_data.start_y);
        check_field("start_z", exp_seg.start_z, out_data.start_z);
        check_field("end_x", exp_seg.end_x, out_data.end_x);
        check_field("end_y", exp_seg.end_y, out_data.end_y);
        check_field("end_z", exp_seg.end_z, out_data.end_z);
        check_field("last", 32'(exp_seg.last), 32'(out_data.last));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (pending_reqs.size() > 30 && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [30:0] r;
    // directed requests: counts, extremes, saturation
    queue_req(32'h00010000, 32'h0, 32'h0, 31'h00010000, 6'd0);
    queue_req(32'h0, 32'h0, 32'h0, 31'h00010000, 6'd1);
    queue_req(32'h0, 32'h0, 32'h0, 31'h00050000, 6'd2);
    queue_req(32'h00030000, 32'hFFFD0000, 32'h1, 31'h00028000, 6'd3);
    queue_req(32'h0, 32'h0, 32'h0, 31'h7FFFFFFF, 6'd4);
    queue_req(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 6'd5);
    queue_req(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 6'd6);
    queue_req(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 31'h0, 6'd7);
    queue_req(32'h0, 32'h0, 32'h0, 31'h00100000, 6'd32);
    queue_req(32'h00010000, 32'h00020000, 32'h00030000, 31'h00010000, 6'd33);
    queue_req(32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 31'h1, 6'd63);
    queue_req(32'h0, 32'h0, 32'h0, 31'h40000000, 6'd31);
    queue_req(32'h0, 32'h0, 32'h0, 31'h00010000, 6'd0);
    queue_req(32'h7FFF0000, 32'h0, 32'h80010000, 31'h00020000, 6'd16);
    // random requests, mostly short spirals
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = 31'($urandom) >> $urandom_range(0, 30);
      queue_req($urandom, $urandom, $urandom, r,
        ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 8)));
    end
    total_reqs = pending_reqs.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (reqs_sent < total_reqs || seg_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d requests (counts 0..63, extreme centres and radii), %0d segments",
             reqs_sent, segs_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
